>>> hw/rtl/rvzex_pkg.sv
// rvzex_pkg: shared types and codes for the rv32i + zicsr execute unit
// no dependencies; compiled first
`default_nettype none

package rvzex_pkg;

  // major opcodes
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_FENCE  = 7'h0f;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [31:0] INST_EBREAK = 32'h0010_0073;
  localparam logic [6:0]  F7_ZERO     = 7'h00;
  localparam logic [6:0]  F7_ALT      = 7'h20;
  localparam logic [4:0]  REG_A0      = 5'd10;

  // memory request codes
  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_STORE = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_LD_PEND = 3'd1;
  localparam logic [2:0] ST_HALT    = 3'd2;
  localparam logic [2:0] ST_ILLEGAL = 3'd3;
  localparam logic [2:0] ST_ORDER   = 3'd4;

  // item opcodes
  localparam logic OP_EXEC = 1'b0;
  localparam logic OP_LDRET = 1'b1;

  // load size codes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;

  typedef struct packed {
    logic        pending;
    logic [4:0]  rd;
    logic [1:0]  size;
    logic        sgn;
  } ld_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [1:0]  mem_req;
    logic [31:0] mem_addr;
    logic [2:0]  mem_bytes;
    logic [31:0] mem_wdata;
    logic [2:0]  status;
    logic [31:0] halt_code;
  } res_t;

  typedef struct packed {
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata;
    logic        csr_we;
    logic [31:0] csr_wdata;
  } wr_t;

endpackage

`default_nettype wire

>>> hw/rtl/rvzex_if.sv
// rvzex_in_if / rvzex_out_if: valid/ready channels of the execute unit
// no dependencies
`default_nettype none

interface rvzex_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] inst;
  logic [31:0] pc;
  logic [31:0] load_data;
  modport source (output valid, op, inst, pc, load_data, input ready);
  modport sink   (input valid, op, inst, pc, load_data, output ready);
endinterface

interface rvzex_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic [1:0]  mem_req;
  logic [31:0] mem_addr;
  logic [2:0]  mem_bytes;
  logic [31:0] mem_wdata;
  logic [2:0]  status;
  logic [31:0] halt_code;
  modport source (output valid, next_pc, mem_req, mem_addr, mem_bytes, mem_wdata,
                  status, halt_code, input ready);
  modport sink   (input valid, next_pc, mem_req, mem_addr, mem_bytes, mem_wdata,
                  status, halt_code, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rvzex_regfile.sv
// rvzex_regfile: 32 x 32 general registers, two synchronous read ports
// with write forwarding and per-entry valid bits; no package use
`default_nettype none

module rvzex_regfile (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        re_i,
  input  wire logic [4:0]  raddr_a_i,
  input  wire logic [4:0]  raddr_b_i,
  output logic [31:0]      rdata_a_o,
  output logic [31:0]      rdata_b_o,
  input  wire logic        we_i,
  input  wire logic [4:0]  waddr_i,
  input  wire logic [31:0] wdata_i
);

  logic [31:0] mem [32];
  logic [31:0] valid_q;
  logic [31:0] rd_a_q, rd_b_q;
  logic [4:0]  ra_q, rb_q;
  logic        wb_en_q;
  logic [4:0]  wb_addr_q;
  logic [31:0] wb_data_q;

  // storage and registered reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_a_q <= mem[raddr_a_i];
      rd_b_q <= mem[raddr_b_i];
    end
  end

  // valid bits, read addresses and last write for forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      ra_q      <= '0;
      rb_q      <= '0;
      wb_en_q   <= 1'b0;
      wb_addr_q <= '0;
      wb_data_q <= '0;
    end else begin
      if (re_i) begin
        ra_q <= raddr_a_i;
        rb_q <= raddr_b_i;
      end
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
        wb_en_q          <= 1'b1;
        wb_addr_q        <= waddr_i;
        wb_data_q        <= wdata_i;
      end
    end
  end

  // write in the read cycle wins, unwritten entries read zero
  always_comb begin
    if (wb_en_q && wb_addr_q == ra_q) begin
      rdata_a_o = wb_data_q;
    end else if (valid_q[ra_q]) begin
      rdata_a_o = rd_a_q;
    end else begin
      rdata_a_o = '0;
    end
    if (wb_en_q && wb_addr_q == rb_q) begin
      rdata_b_o = wb_data_q;
    end else if (valid_q[rb_q]) begin
      rdata_b_o = rd_b_q;
    end else begin
      rdata_b_o = '0;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rvzex_csr_ram.sv
// rvzex_csr_ram: flat csr store in one synchronous memory, cleared by a
// sweep after reset, with write forwarding; no package use
`default_nettype none

module rvzex_csr_ram #(
  parameter int unsigned AddrBits = 12
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  output logic                     busy_o,
  input  wire logic                re_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output logic [31:0]              rdata_o,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire logic [31:0]         wdata_i
);

  localparam int unsigned Depth = 1 << AddrBits;

  logic [31:0]         mem [Depth];
  logic [AddrBits:0]   clr_cnt_q;
  logic [31:0]         rd_q;
  logic [AddrBits-1:0] ra_q;
  logic                wb_en_q;
  logic [AddrBits-1:0] wb_addr_q;
  logic [31:0]         wb_data_q;

  assign busy_o = !clr_cnt_q[AddrBits];

  // single write port shared by the clearing sweep
  always_ff @(posedge clk_i) begin
    if (busy_o) begin
      mem[clr_cnt_q[AddrBits-1:0]] <= '0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem[raddr_i];
    end
  end

  // sweep counter and forwarding state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      ra_q      <= '0;
      wb_en_q   <= 1'b0;
      wb_addr_q <= '0;
      wb_data_q <= '0;
    end else begin
      if (busy_o) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (re_i) begin
        ra_q <= raddr_i;
      end
      if (we_i && !busy_o) begin
        wb_en_q   <= 1'b1;
        wb_addr_q <= waddr_i;
        wb_data_q <= wdata_i;
      end
    end
  end

  assign rdata_o = (wb_en_q && wb_addr_q == ra_q) ? wb_data_q : rd_q;

endmodule

`default_nettype wire

>>> hw/rtl/rvzex_exec.sv
// rvzex_exec: decode and execute of one word from its operands
// depends on rvzex_pkg
`default_nettype none

module rvzex_exec (
  input  wire logic        op_i,
  input  wire logic [31:0] inst_i,
  input  wire logic [31:0] pc_i,
  input  wire logic [31:0] load_data_i,
  input  wire logic [31:0] rs1_i,
  input  wire logic [31:0] rs2_i,
  input  wire logic [31:0] a0_i,
  input  wire logic [31:0] csr_i,
  input  wire rvzex_pkg::ld_t ld_i,
  output rvzex_pkg::ld_t   ld_o,
  output rvzex_pkg::res_t  res_o,
  output rvzex_pkg::wr_t   wr_o
);
  import rvzex_pkg::*;

  logic [6:0]  opc, f7;
  logic [4:0]  rd, rs1f, shamt;
  logic [2:0]  f3;
  logic [31:0] immi, imms, immb, immu, immj, seq, src, ld_val;
  logic        take, wreg;
  logic [31:0] wval;

  assign opc   = inst_i[6:0];
  assign rd    = inst_i[11:7];
  assign f3    = inst_i[14:12];
  assign rs1f  = inst_i[19:15];
  assign f7    = inst_i[31:25];
  assign immi  = {{20{inst_i[31]}}, inst_i[31:20]};
  assign imms  = {{20{inst_i[31]}}, inst_i[31:25], inst_i[11:7]};
  assign immb  = {{19{inst_i[31]}}, inst_i[31], inst_i[7], inst_i[30:25], inst_i[11:8], 1'b0};
  assign immu  = {inst_i[31:12], 12'b0};
  assign immj  = {{11{inst_i[31]}}, inst_i[31], inst_i[19:12], inst_i[20], inst_i[30:21], 1'b0};
  assign seq   = pc_i + 32'd4;
  assign shamt = (opc == OPC_OP) ? rs2_i[4:0] : inst_i[24:20];
  assign src   = f3[2] ? {27'b0, rs1f} : rs1_i;

  // load return extension
  always_comb begin
    unique case (ld_i.size)
      SZ_BYTE: ld_val = ld_i.sgn ? {{24{load_data_i[7]}}, load_data_i[7:0]}
                                 : {24'b0, load_data_i[7:0]};
      SZ_HALF: ld_val = ld_i.sgn ? {{16{load_data_i[15]}}, load_data_i[15:0]}
                                 : {16'b0, load_data_i[15:0]};
      default: ld_val = load_data_i;
    endcase
  end

  // main decode
  always_comb begin
    res_o          = '0;
    ld_o           = ld_i;
    wreg           = 1'b0;
    wval           = '0;
    take           = 1'b0;
    wr_o           = '0;
    wr_o.rf_waddr  = rd;
    wr_o.csr_wdata = src;
    if (op_i == OP_LDRET) begin
      if (!ld_i.pending) begin
        res_o.status = ST_ORDER;
      end else begin
        wreg          = 1'b1;
        wval          = ld_val;
        wr_o.rf_waddr = ld_i.rd;
        ld_o.pending  = 1'b0;
      end
    end else if (ld_i.pending) begin
      res_o.status = ST_ORDER;
    end else begin
      res_o.next_pc = seq;
      unique case (opc)
        OPC_LUI: begin
          wreg = 1'b1;
          wval = immu;
        end
        OPC_AUIPC: begin
          wreg = 1'b1;
          wval = pc_i + immu;
        end
        OPC_OPIMM: begin
          wreg = 1'b1;
          unique case (f3)
            3'd0: wval = rs1_i + immi;
            3'd2: wval = {31'b0, $signed(rs1_i) < $signed(immi)};
            3'd3: wval = {31'b0, rs1_i < immi};
            3'd4: wval = rs1_i ^ immi;
            3'd6: wval = rs1_i | immi;
            3'd7: wval = rs1_i & immi;
            3'd1: begin
              if (f7 == F7_ZERO) begin
                wval = rs1_i << shamt;
              end else begin
                wreg = 1'b0;
                res_o.status = ST_ILLEGAL;
              end
            end
            default: begin
              if (f7 == F7_ZERO) begin
                wval = rs1_i >> shamt;
              end else if (f7 == F7_ALT) begin
                wval = $unsigned($signed(rs1_i) >>> shamt);
              end else begin
                wreg = 1'b0;
                res_o.status = ST_ILLEGAL;
              end
            end
          endcase
        end
        OPC_OP: begin
          wreg = 1'b1;
          if (f7 == F7_ZERO) begin
            unique case (f3)
              3'd0: wval = rs1_i + rs2_i;
              3'd1: wval = rs1_i << shamt;
              3'd2: wval = {31'b0, $signed(rs1_i) < $signed(rs2_i)};
              3'd3: wval = {31'b0, rs1_i < rs2_i};
              3'd4: wval = rs1_i ^ rs2_i;
              3'd5: wval = rs1_i >> shamt;
              3'd6: wval = rs1_i | rs2_i;
              default: wval = rs1_i & rs2_i;
            endcase
          end else if (f7 == F7_ALT && f3 == 3'd0) begin
            wval = rs1_i - rs2_i;
          end else if (f7 == F7_ALT && f3 == 3'd5) begin
            wval = $unsigned($signed(rs1_i) >>> shamt);
          end else begin
            wreg = 1'b0;
            res_o.status = ST_ILLEGAL;
          end
        end
        OPC_BRANCH: begin
          unique case (f3)
            3'd0: take = rs1_i == rs2_i;
            3'd1: take = rs1_i != rs2_i;
            3'd4: take = $signed(rs1_i) < $signed(rs2_i);
            3'd5: take = !($signed(rs1_i) < $signed(rs2_i));
            3'd6: take = rs1_i < rs2_i;
            3'd7: take = rs1_i >= rs2_i;
            default: res_o.status = ST_ILLEGAL;
          endcase
          if (take) begin
            res_o.next_pc = pc_i + immb;
          end
        end
        OPC_LOAD: begin
          if (f3 == 3'd3 || f3 > 3'd5) begin
            res_o.status = ST_ILLEGAL;
          end else begin
            res_o.mem_req   = REQ_LOAD;
            res_o.mem_addr  = rs1_i + immi;
            res_o.status    = ST_LD_PEND;
            res_o.mem_bytes = (f3[1:0] == SZ_BYTE) ? 3'd1 :
                              (f3[1:0] == SZ_HALF) ? 3'd2 : 3'd4;
            ld_o.pending    = 1'b1;
            ld_o.rd         = rd;
            ld_o.size       = f3[1:0];
            ld_o.sgn        = !f3[2];
          end
        end
        OPC_STORE: begin
          if (f3 > 3'd2) begin
            res_o.status = ST_ILLEGAL;
          end else begin
            res_o.mem_req   = REQ_STORE;
            res_o.mem_addr  = rs1_i + imms;
            res_o.mem_wdata = rs2_i;
            res_o.mem_bytes = (f3 == 3'd0) ? 3'd1 : (f3 == 3'd1) ? 3'd2 : 3'd4;
          end
        end
        OPC_FENCE: begin
          if (f3 > 3'd1) begin
            res_o.status = ST_ILLEGAL;
          end
        end
        OPC_JAL: begin
          res_o.next_pc = pc_i + immj;
          wreg = 1'b1;
          wval = seq;
        end
        OPC_JALR: begin
          if (f3 != 3'd0) begin
            res_o.status = ST_ILLEGAL;
          end else begin
            res_o.next_pc = (rs1_i + immi) & ~32'd1;
            wreg = 1'b1;
            wval = seq;
          end
        end
        OPC_SYSTEM: begin
          if (f3 == 3'd0) begin
            if (inst_i == INST_EBREAK) begin
              res_o.status    = ST_HALT;
              res_o.halt_code = a0_i;
            end else begin
              res_o.status = ST_ILLEGAL;
            end
          end else if (f3 == 3'd4) begin
            res_o.status = ST_ILLEGAL;
          end else begin
            // csr read-modify-write; set and clear skip the write on zero rs1
            wreg = 1'b1;
            wval = csr_i;
            unique case (f3[1:0])
              2'd1: begin
                wr_o.csr_we    = 1'b1;
                wr_o.csr_wdata = src;
              end
              2'd2: begin
                wr_o.csr_we    = rs1f != 5'd0;
                wr_o.csr_wdata = csr_i | src;
              end
              default: begin
                wr_o.csr_we    = rs1f != 5'd0;
                wr_o.csr_wdata = csr_i & ~src;
              end
            endcase
          end
        end
        default: res_o.status = ST_ILLEGAL;
      endcase
    end
    wr_o.rf_we    = wreg && (wr_o.rf_waddr != 5'd0);
    wr_o.rf_wdata = wval;
  end

endmodule

`default_nettype wire

>>> hw/rtl/rv32i_zicsr_execute_unit.sv
// rv32i_zicsr_execute_unit: top level of the rv32i + zicsr execute unit
// depends on rvzex_pkg, rvzex_if, rvzex_regfile, rvzex_csr_ram, rvzex_exec
`default_nettype none

// One word in, one result word out, one instruction per cycle sustained
// while results are taken. An accepted word reads its operands from the
// register file and csr memories at the accept edge, executes in the next
// cycle and writes back as it moves into the output register, so a result
// passes through the execute stage and the output register before it is
// offered; writes of the preceding word are forwarded. After reset the
// 2**CSR_ADDR_BITS csr entries (4096 by default) are swept to zero, and
// no word is accepted until the sweep ends. The output register decouples
// the two sides, so one more word is taken into the execute stage while a
// result waits; after that the input stalls until the result is taken.
module rv32i_zicsr_execute_unit #(
  parameter int unsigned CSR_ADDR_BITS = 12
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  rvzex_in_if.sink     in_i,
  rvzex_out_if.source  out_o
);
  import rvzex_pkg::*;

  logic        s1_valid_q, s1_adv, in_acc, csr_busy;
  logic        s1_op_q;
  logic [31:0] s1_inst_q, s1_pc_q, s1_ldata_q;
  logic [31:0] rs1_val, rs2_val, csr_val, a0_q;
  ld_t         ld_q, ld_d;
  res_t        res, out_q;
  wr_t         wr;
  logic        out_valid_q;
  logic        rf_we, csr_we;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !csr_busy && (!s1_valid_q || s1_adv);
  assign in_acc     = in_i.valid && in_i.ready;
  assign rf_we      = s1_adv && wr.rf_we;
  assign csr_we     = s1_adv && wr.csr_we;

  // operand memories
  rvzex_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .re_i      (in_acc),
    .raddr_a_i (in_i.inst[19:15]),
    .raddr_b_i (in_i.inst[24:20]),
    .rdata_a_o (rs1_val),
    .rdata_b_o (rs2_val),
    .we_i      (rf_we),
    .waddr_i   (wr.rf_waddr),
    .wdata_i   (wr.rf_wdata)
  );

  rvzex_csr_ram #(
    .AddrBits (CSR_ADDR_BITS)
  ) u_csr_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .busy_o  (csr_busy),
    .re_i    (in_acc),
    .raddr_i (in_i.inst[20 +: CSR_ADDR_BITS]),
    .rdata_o (csr_val),
    .we_i    (csr_we),
    .waddr_i (s1_inst_q[20 +: CSR_ADDR_BITS]),
    .wdata_i (wr.csr_wdata)
  );

  // execute stage
  rvzex_exec u_exec (
    .op_i        (s1_op_q),
    .inst_i      (s1_inst_q),
    .pc_i        (s1_pc_q),
    .load_data_i (s1_ldata_q),
    .rs1_i       (rs1_val),
    .rs2_i       (rs2_val),
    .a0_i        (a0_q),
    .csr_i       (csr_val),
    .ld_i        (ld_q),
    .ld_o        (ld_d),
    .res_o       (res),
    .wr_o        (wr)
  );

  // execute stage payload and output register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q    <= in_i.op;
      s1_inst_q  <= in_i.inst;
      s1_pc_q    <= in_i.pc;
      s1_ldata_q <= in_i.load_data;
    end
    if (s1_adv) begin
      out_q <= res;
    end
  end

  // control, load tracking and a0 shadow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ld_q        <= '0;
      a0_q        <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        ld_q        <= ld_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (rf_we && wr.rf_waddr == REG_A0) begin
        a0_q <= wr.rf_wdata;
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.next_pc   = out_q.next_pc;
  assign out_o.mem_req   = out_q.mem_req;
  assign out_o.mem_addr  = out_q.mem_addr;
  assign out_o.mem_bytes = out_q.mem_bytes;
  assign out_o.mem_wdata = out_q.mem_wdata;
  assign out_o.status    = out_q.status;
  assign out_o.halt_code = out_q.halt_code;

`ifndef SYNTHESIS
  // no word enters while the csr sweep runs
  a_sweep_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    csr_busy |-> !in_i.ready) else $error("word accepted during csr sweep");

  // x0 is never written
  a_no_x0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> wr.rf_waddr != 5'd0) else $error("write to x0");

  // a load request always leaves a load pending
  a_ld_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && res.mem_req == REQ_LOAD) |=> ld_q.pending)
    else $error("load issued without pending state");
`endif

endmodule

`default_nettype wire

>>> test/rv32i_zicsr_execute_unit_checker.sv
// checker for the rv32i + zicsr execute unit: watches both channels,
// predicts each result word and compares it field by field
// depends on rvzex_pkg
`timescale 1ns / 1ps

module rv32i_zicsr_execute_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        in_op_i,
  input  logic [31:0] in_inst_i,
  input  logic [31:0] in_pc_i,
  input  logic [31:0] in_load_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  rvzex_pkg::res_t out_res_i,
  output int          fail_count_o,
  output int          pending_o
);
  import rvzex_pkg::*;

  // architectural copy of the unit
  logic [31:0] xreg [32];
  logic [31:0] csr_mem [4096];
  ld_t         ld_state;
  res_t        result_q [$];

  assign pending_o = result_q.size();

  function automatic logic [31:0] sx(logic [31:0] v, int bits);
    logic [31:0] m;
    m = 32'd1 << (bits - 1);
    v = v & ((m << 1) - 1);
    return (v ^ m) - m;
  endfunction

  function automatic logic slt(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic void put_reg(logic [4:0] rd, logic [31:0] v);
    if (rd != 5'd0) xreg[rd] = v;
  endfunction

  // execute one accepted word against the shadow state
  function automatic res_t execute_word(logic op, logic [31:0] inst, logic [31:0] pc,
                                        logic [31:0] ldata);
    res_t r;
    logic [6:0] opc, f7;
    logic [4:0] rd, rs1;
    logic [2:0] f3;
    logic [31:0] a, b, immi, imms, immb, immj, seq, v, old, src;
    logic [11:0] ci;
    logic take;
    r = '0;
    opc = inst[6:0]; rd = inst[11:7]; f3 = inst[14:12]; rs1 = inst[19:15];
    f7 = inst[31:25];
    a = xreg[rs1]; b = xreg[inst[24:20]];
    immi = sx(inst >> 20, 12);
    imms = sx({inst[31:25], inst[11:7]}, 12);
    immb = sx({inst[31], inst[7], inst[30:25], inst[11:8], 1'b0}, 13);
    immj = sx({inst[31], inst[19:12], inst[20], inst[30:21], 1'b0}, 21);
    seq = pc + 32'd4;
    if (op == OP_LDRET) begin
      if (!ld_state.pending) begin
        r.status = ST_ORDER;
      end else begin
        if (ld_state.size == SZ_BYTE) v = ld_state.sgn ? sx(ldata, 8) : {24'd0, ldata[7:0]};
        else if (ld_state.size == SZ_HALF) v = ld_state.sgn ? sx(ldata, 16)
                                                          : {16'd0, ldata[15:0]};
        else v = ldata;
        put_reg(ld_state.rd, v);
        ld_state.pending = 1'b0;
      end
      return r;
    end
    if (ld_state.pending) begin
      r.status = ST_ORDER;
      return r;
    end
    r.next_pc = seq;
    case (opc)
      OPC_LUI:   put_reg(rd, {inst[31:12], 12'd0});
      OPC_AUIPC: put_reg(rd, pc + {inst[31:12], 12'd0});
      OPC_OPIMM: case (f3)
        3'd0: put_reg(rd, a + immi);
        3'd2: put_reg(rd, {31'd0, slt(a, immi)});
        3'd3: put_reg(rd, {31'd0, a < immi});
        3'd4: put_reg(rd, a ^ immi);
        3'd6: put_reg(rd, a | immi);
        3'd7: put_reg(rd, a & immi);
        3'd1: if (f7 == F7_ZERO) put_reg(rd, a << immi[4:0]); else r.status = ST_ILLEGAL;
        default:
          if (f7 == F7_ZERO) put_reg(rd, a >> immi[4:0]);
          else if (f7 == F7_ALT) put_reg(rd, $signed(a) >>> immi[4:0]);
          else r.status = ST_ILLEGAL;
      endcase
      OPC_OP:
        if (f7 == F7_ZERO) begin
          case (f3)
            3'd0: put_reg(rd, a + b);
            3'd1: put_reg(rd, a << b[4:0]);
            3'd2: put_reg(rd, {31'd0, slt(a, b)});
            3'd3: put_reg(rd, {31'd0, a < b});
            3'd4: put_reg(rd, a ^ b);
            3'd5: put_reg(rd, a >> b[4:0]);
            3'd6: put_reg(rd, a | b);
            default: put_reg(rd, a & b);
          endcase
        end else if (f7 == F7_ALT && f3 == 3'd0) put_reg(rd, a - b);
        else if (f7 == F7_ALT && f3 == 3'd5) put_reg(rd, $signed(a) >>> b[4:0]);
        else r.status = ST_ILLEGAL;
      OPC_BRANCH: begin
        take = 1'b0;
        case (f3)
          3'd0: take = a == b;
          3'd1: take = a != b;
          3'd4: take = slt(a, b);
          3'd5: take = !slt(a, b);
          3'd6: take = a < b;
          3'd7: take = a >= b;
          default: r.status = ST_ILLEGAL;
        endcase
        if (take) r.next_pc = pc + immb;
      end
      OPC_LOAD:
        if (f3 == 3'd3 || f3 > 3'd5) r.status = ST_ILLEGAL;
        else begin
          r.mem_req = REQ_LOAD; r.mem_addr = a + immi; r.status = ST_LD_PEND;
          ld_state.size = f3[1:0];
          r.mem_bytes = (f3[1:0] == SZ_BYTE) ? 3'd1 : (f3[1:0] == SZ_HALF) ? 3'd2 : 3'd4;
          ld_state.sgn = !f3[2];
          ld_state.rd = rd;
          ld_state.pending = 1'b1;
        end
      OPC_STORE:
        if (f3 > 3'd2) r.status = ST_ILLEGAL;
        else begin
          r.mem_req = REQ_STORE; r.mem_addr = a + imms; r.mem_wdata = b;
          r.mem_bytes = (f3 == 3'd0) ? 3'd1 : (f3 == 3'd1) ? 3'd2 : 3'd4;
        end
      OPC_FENCE: if (f3 > 3'd1) r.status = ST_ILLEGAL;
      OPC_JAL: begin
        r.next_pc = pc + immj;
        put_reg(rd, seq);
      end
      OPC_JALR:
        if (f3 != 3'd0) r.status = ST_ILLEGAL;
        else begin
          r.next_pc = (a + immi) & ~32'd1;
          put_reg(rd, seq);
        end
      OPC_SYSTEM:
        if (f3 == 3'd0) begin
          if (inst == INST_EBREAK) begin
            r.status = ST_HALT; r.halt_code = xreg[REG_A0];
          end else r.status = ST_ILLEGAL;
        end else if (f3 == 3'd4) r.status = ST_ILLEGAL;
        else begin
          ci = inst[31:20];
          old = csr_mem[ci];
          src = f3[2] ? {27'd0, rs1} : a;
          if (f3[1:0] == 2'd1) csr_mem[ci] = src;
          else if (f3[1:0] == 2'd2) begin
            if (rs1 != 5'd0) csr_mem[ci] = old | src;
          end else if (rs1 != 5'd0) csr_mem[ci] = old & ~src;
          put_reg(rd, old);
        end
      default: r.status = ST_ILLEGAL;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    ld_state = '0;
    foreach (xreg[i]) xreg[i] = '0;
    foreach (csr_mem[i]) csr_mem[i] = '0;
  end

  // compare the output word first, then account for the input word
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $display("%0t unexpected result word", $time);
          fail_count_o++;
        end else begin
          want = result_q.pop_front();
          if (out_res_i.next_pc !== want.next_pc)
            report_mismatch("next_pc", out_res_i.next_pc, want.next_pc);
          if (out_res_i.mem_req !== want.mem_req)
            report_mismatch("mem_req", out_res_i.mem_req, want.mem_req);
          if (out_res_i.mem_addr !== want.mem_addr)
            report_mismatch("mem_addr", out_res_i.mem_addr, want.mem_addr);
          if (out_res_i.mem_bytes !== want.mem_bytes)
            report_mismatch("mem_bytes", out_res_i.mem_bytes, want.mem_bytes);
          if (out_res_i.mem_wdata !== want.mem_wdata)
            report_mismatch("mem_wdata", out_res_i.mem_wdata, want.mem_wdata);
          if (out_res_i.status !== want.status)
            report_mismatch("status", out_res_i.status, want.status);
          if (out_res_i.halt_code !== want.halt_code)
            report_mismatch("halt_code", out_res_i.halt_code, want.halt_code);
        end
      end
      if (in_valid_i && in_ready_i)
        result_q.push_back(execute_word(in_op_i, in_inst_i, in_pc_i, in_load_data_i));
    end
  end
endmodule

>>> test/rv32i_zicsr_execute_unit_test.sv
// testbench top for the rv32i + zicsr execute unit: drives instruction and
// load return words with random gaps and stalls, and gives the verdict
// depends on rvzex_pkg, rvzex_if, the unit and its checker
`timescale 1ns / 1ps

module rv32i_zicsr_execute_unit_test;
  import rvzex_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, idle_cycles;
  logic done = 1'b0;
  logic load_open = 1'b0;
  logic [31:0] pc_next = 32'h0000_1000;
  res_t out_res;

  rvzex_in_if  in_ch ();
  rvzex_out_if out_ch ();

  rv32i_zicsr_execute_unit dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));

  assign out_res = '{out_ch.next_pc, out_ch.mem_req, out_ch.mem_addr, out_ch.mem_bytes,
                     out_ch.mem_wdata, out_ch.status, out_ch.halt_code};

  rv32i_zicsr_execute_unit_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready), .in_op_i(in_ch.op),
    .in_inst_i(in_ch.inst), .in_pc_i(in_ch.pc), .in_load_data_i(in_ch.load_data),
    .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready), .out_res_i(out_res),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0; in_ch.op = OP_EXEC; in_ch.inst = '0; in_ch.pc = '0;
    in_ch.load_data = '0; out_ch.ready = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
  end

  // send one word, with a random gap in front of it
  task automatic send_word(logic op, logic [31:0] inst, logic [31:0] pc, logic [31:0] ldata);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1; in_ch.op <= op; in_ch.inst <= inst; in_ch.pc <= pc;
    in_ch.load_data <= ldata;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 11));
  endfunction

  // build a mostly well formed instruction with random fields
  function automatic logic [31:0] make_inst();
    logic [31:0] w;
    logic [6:0] opc;
    logic [2:0] f3;
    logic [6:0] f7;
    w = $urandom();
    case ($urandom_range(0, 12))
      0: opc = OPC_LUI;    1: opc = OPC_AUIPC;  2, 3: opc = OPC_OPIMM;
      4, 5: opc = OPC_OP;  6: opc = OPC_BRANCH; 7: opc = OPC_LOAD;
      8: opc = OPC_STORE;  9: opc = OPC_FENCE;  10: opc = OPC_JAL;
      11: opc = ($urandom_range(0, 1) != 0) ? OPC_JALR : OPC_SYSTEM;
      default: opc = ($urandom_range(0, 3) == 0) ? 7'($urandom()) : OPC_SYSTEM;
    endcase
    f3 = w[14:12];
    f7 = ($urandom_range(0, 9) == 0) ? w[31:25]
         : ($urandom_range(0, 1) != 0) ? F7_ZERO : F7_ALT;
    if (opc == OPC_OP || (opc == OPC_OPIMM && (f3 == 3'd1 || f3 == 3'd5))) w[31:25] = f7;
    if (opc == OPC_SYSTEM && $urandom_range(0, 2) != 0) w[31:20] = 12'($urandom_range(0, 7));
    if (opc == OPC_SYSTEM && $urandom_range(0, 9) == 0) return INST_EBREAK;
    w[11:7] = pick_reg();
    w[19:15] = pick_reg();
    w[24:20] = (opc == OPC_SYSTEM) ? w[24:20] : pick_reg();
    w[6:0] = opc;
    return w;
  endfunction

  task automatic run_inst(logic [31:0] inst);
    logic [31:0] pc;
    pc = ($urandom_range(0, 15) == 0) ? $urandom() : pc_next;
    send_word(OP_EXEC, inst, pc, $urandom());
    pc_next = pc + 32'd4;
    if (inst[6:0] == OPC_LOAD && !(inst[14:12] == 3'd3 || inst[14:12] > 3'd5))
      load_open = 1'b1;
  endtask

  task automatic run_return(logic [31:0] data);
    send_word(OP_LDRET, $urandom(), $urandom(), data);
    load_open = 1'b0;
  endtask

  // stimulus
  initial begin
    @(posedge rst_ni);
    @(negedge clk_i);
    // directed: extremes and each special case
    run_inst(32'hfff0_0513);            // addi a0, x0, -1
    run_inst(32'h8000_05b7);            // lui a1, 0x80000
    run_inst(32'h4015_d613);            // srai a2, a1, 1
    run_inst(32'h40b5_06b3);            // sub a3, a0, a1
    run_inst(32'h0015_a713);            // slti a4, a1, 1
    run_inst(32'h3405_1073);            // csrrw x0, 0x340, a0
    run_inst(32'h3400_27f3);            // csrrs a5, 0x340, x0 (no write)
    run_inst(32'h3401_f7f3);            // csrrci a5, 0x340, 3
    run_inst(32'hfff5_0783);            // lb a5, -1(a0)
    run_inst(32'h0000_0013);            // instruction while load pending
    run_return(32'h0000_0080);
    run_return(32'h1234_5678);          // return without a load
    run_inst(32'h0005_5003);            // lhu x0, 0(a0): data dropped
    run_return(32'hffff_ffff);
    run_inst(32'h0005_2803);            // lw a6, 0(a0)
    run_return(32'hffff_ffff);
    run_inst(32'h00b5_2023);            // sw a1, 0(a0)
    run_inst(32'h0000_100f);            // fence.i
    run_inst(32'hfe05_8ee3);            // beq a1, x0 (not taken)
    run_inst(32'hfff0_08ef);            // jal a7, back
    run_inst(32'hfff5_0567);            // jalr a0, -1(a0)
    run_inst(32'h0000_0073);            // ecall is illegal
    run_inst(INST_EBREAK);
    run_inst(32'hffff_ffff);
    run_inst(32'h0000_0000);
    // random part
    for (int n = 0; n < 500; n++) begin
      if (load_open && $urandom_range(0, 7) != 0) run_return($urandom());
      else if ($urandom_range(0, 19) == 0) run_return($urandom());
      else if ($urandom_range(0, 19) == 0) run_inst($urandom());
      else run_inst(make_inst());
    end
    in_ch.valid <= 1'b0;
    done <= 1'b1;
  end

  // result side stalls, with stretches of none
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // watchdog and verdict
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (done && pending == 0) begin
        repeat (20) @(posedge clk_i);
        if (fail_count == 0 && pending == 0) $display("** rv32i_zicsr_execute_unit: PASSED **");
        else $display("** rv32i_zicsr_execute_unit: FAILED **");
        $finish;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout with %0d results outstanding", pending);
        $display("** rv32i_zicsr_execute_unit: FAILED **");
        $finish;
      end
    end
  end
endmodule
